// ===== rtl/kcs_pkg.sv =====
// ============================================================================
// kcs_pkg: shared constants of the keyframe curve sampler
// Field widths, configuration register indexes and mode codes.
// ============================================================================
`default_nettype none

package kcs_pkg;

    localparam int KEY_DEPTH_DEF = 64;
    localparam int FRAC_BITS_DEF = 16;

    localparam int DATA_W      = 32;
    localparam int SLOT_W      = 6;
    localparam int COUNT_W     = 7;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_TDATA_W  = 168;
    localparam int OUT_TDATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERP_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_MODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_STOP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_SCALE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_OFFSET = 3'd6;

    // interpolation modes (the unused code acts as linear)
    localparam logic [MODE_W-1:0] INTERP_LINEAR  = 2'd0;
    localparam logic [MODE_W-1:0] INTERP_HERMITE = 2'd1;
    localparam logic [MODE_W-1:0] INTERP_STEP    = 2'd2;

    // cycle modes (the unused code acts as clamp)
    localparam logic [MODE_W-1:0] CYCLE_LOOP     = 2'd0;
    localparam logic [MODE_W-1:0] CYCLE_PINGPONG = 2'd1;
    localparam logic [MODE_W-1:0] CYCLE_CLAMP    = 2'd2;

    // commands
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/kcs_div.sv =====
// ============================================================================
// kcs_div: unsigned restoring divider
// One quotient bit per cycle; quotient and remainder hold after done.
// ============================================================================
`default_nettype none

module kcs_div #(
    parameter int DVD_W = kcs_pkg::DATA_W + kcs_pkg::FRAC_BITS_DEF,
    parameter int DVS_W = kcs_pkg::DATA_W
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic      [DVD_W-1:0] quotient,
    output logic      [DVS_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_sub;
    logic             ge;

    assign rem_sh  = {rem_reg, quo_reg[DVD_W-1]};
    assign ge      = (rem_sh >= {1'b0, dvs_reg});
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = CNT_W'(DVD_W);
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            // shift in the next dividend bit, subtract where it fits
            cnt_next  = cnt_reg - CNT_W'(1);
            quo_next  = {quo_reg[DVD_W-2:0], ge};
            rem_next  = ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/keyframe_curve_sampler_core.sv =====
// ============================================================================
// keyframe_curve_sampler_core: keyframe curve sampler, signed fixed point
// Stores keys and samples a linear, cubic Hermite or step curve between them.
// ============================================================================
// A write transfer (tuser = 0) stores one key and gives no result. A sample
// transfer (tuser = 1) gives exactly one result transfer and is worked
// through by a sequencer around one shared 33 x 33 multiplier and one
// restoring divider. A sample steps one key at a time from the cached key
// index to the bracketing keys and needs one division when the mapped time
// falls in the interior of the key range, plus a second division when a
// loop or ping-pong fold is needed; Hermite adds further multiplier steps.
// The default format is Q16.16. The divider and the single read port of
// the key memory set how long a sample takes. The block takes no transfer
// while a sample is in work; a finished result waits in an output register,
// so the next transfer is taken while it is still pending. Keys are
// undefined until written; write them in ascending time order.
// ============================================================================
`default_nettype none

module keyframe_curve_sampler_core #(
    parameter int KEY_DEPTH = kcs_pkg::KEY_DEPTH_DEF,
    parameter int FRAC_BITS = kcs_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration write port
    input  wire logic                                cfg_we,
    input  wire logic [kcs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [kcs_pkg::DATA_W-1:0]          cfg_data,
    // input stream
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // key_slot[5:0], key_time[37:6], key_value[69:38], key_tangent_in[101:70],
    // key_tangent_out[133:102], sample_time[165:134], zero fill[167:166]
    input  wire logic [kcs_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // command[0]
    input  wire logic [0:0]                          s_axis_tuser,
    // output stream
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // sampled_value[31:0]
    output logic [kcs_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    // sample_valid[0]
    output logic [0:0]                               m_axis_tuser
);

    localparam int DW    = kcs_pkg::DATA_W;
    localparam int IW    = $clog2(KEY_DEPTH);
    localparam int CW    = $clog2(KEY_DEPTH + 1);
    localparam int XW    = FRAC_BITS + 1;
    localparam int HW    = FRAC_BITS + 4;
    localparam int MW    = DW + 1;
    localparam int PW    = 2 * MW;
    localparam int AW    = PW + 2;
    localparam int DVD_W = DW + FRAC_BITS;
    localparam int WW    = 4 * DW;

    localparam logic [XW-1:0]        ONE_X     = XW'(1) << FRAC_BITS;
    localparam logic [XW-1:0]        HALF_X    = XW'(1) << (FRAC_BITS - 1);
    localparam logic signed [HW-1:0] ONE_H     = HW'(1) <<< FRAC_BITS;
    localparam logic signed [DW-1:0] SCALE_RST = DW'(1) <<< FRAC_BITS;
    localparam logic signed [AW-1:0] SAT_MAX   = {{(AW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [AW-1:0] SAT_MIN   = ~SAT_MAX;

    typedef enum logic [26:0] {
        S_IDLE  = 27'h0000001,
        S_MAP   = 27'h0000002,
        S_FOLD  = 27'h0000004,
        S_RANGE = 27'h0000008,
        S_MOD   = 27'h0000010,
        S_SRCH0 = 27'h0000020,
        S_SRCH1 = 27'h0000040,
        S_SRCH2 = 27'h0000080,
        S_SRCH3 = 27'h0000100,
        S_FWD   = 27'h0000200,
        S_BWD   = 27'h0000400,
        S_DIV   = 27'h0000800,
        S_VA    = 27'h0001000,
        S_VB    = 27'h0002000,
        S_VC    = 27'h0004000,
        S_LM    = 27'h0008000,
        S_LFIN  = 27'h0010000,
        S_HX2   = 27'h0020000,
        S_HX3   = 27'h0040000,
        S_HH    = 27'h0080000,
        S_HM0   = 27'h0100000,
        S_HM1   = 27'h0200000,
        S_HM2   = 27'h0400000,
        S_HM3   = 27'h0800000,
        S_HM4   = 27'h1000000,
        S_HFIN  = 27'h2000000,
        S_OUT   = 27'h4000000
    } state_t;

    function automatic logic signed [DW-1:0] sat32(input logic signed [AW-1:0] v);
        logic signed [DW-1:0] r;
        priority if (v > SAT_MAX)
            r = DW'(SAT_MAX);
        else if (v < SAT_MIN)
            r = DW'(SAT_MIN);
        else
            r = DW'(v);
        return r;
    endfunction

    // ---------------------------------------------------------------- state
    state_t state_reg, state_next;

    // configuration registers
    logic [kcs_pkg::COUNT_W-1:0] key_count_reg;
    logic [kcs_pkg::MODE_W-1:0]  interp_reg;
    logic [kcs_pkg::MODE_W-1:0]  cycle_reg;
    logic signed [DW-1:0]        start_reg;
    logic signed [DW-1:0]        stop_reg;
    logic signed [DW-1:0]        scale_reg;
    logic signed [DW-1:0]        offset_reg;

    // control
    logic          out_valid_reg, out_valid_next;
    logic          div_start_reg, div_start_next;
    logic [IW-1:0] cached_reg, cached_next;

    // payload
    logic [DW-1:0]         out_data_reg, out_data_next;
    logic                  out_flag_reg, out_flag_next;
    logic signed [DW-1:0]  res_val_reg, res_val_next;
    logic                  res_ok_reg, res_ok_next;
    logic signed [DW-1:0]  tin_reg, tin_next;
    logic signed [PW-1:0]  prod_reg, prod_next;
    logic signed [DW-1:0]  t_reg, t_next;
    logic signed [DW-1:0]  tf_reg, tf_next;
    logic [DW-1:0]         delta_reg, delta_next;
    logic                  dneg_reg, dneg_next;
    logic                  bneg_reg, bneg_next;
    logic [IW-1:0]         i_reg, i_next;
    logic [IW-1:0]         j_reg, j_next;
    logic [IW-1:0]         a_reg, a_next;
    logic [IW-1:0]         b_reg, b_next;
    logic signed [DW-1:0]  ti_reg, ti_next;
    logic [XW-1:0]         x_reg, x_next;
    logic signed [HW-1:0]  x2_reg, x2_next;
    logic signed [HW-1:0]  h00_reg, h00_next;
    logic signed [HW-1:0]  h01_reg, h01_next;
    logic signed [HW-1:0]  h10_reg, h10_next;
    logic signed [HW-1:0]  h11_reg, h11_next;
    logic signed [AW-1:0]  acc_reg, acc_next;
    logic signed [DW-1:0]  v1_reg, v1_next;
    logic signed [DW-1:0]  v2_reg, v2_next;
    logic signed [DW-1:0]  tout_reg, tout_next;
    logic signed [DW-1:0]  tinb_reg, tinb_next;
    logic [DVD_W-1:0]      div_dvd_reg, div_dvd_next;
    logic [DW-1:0]         div_dvs_reg, div_dvs_next;
    logic [WW-1:0]         mem_q_reg;

    // key memory: time[31:0], value[63:32], tangent_in[95:64], tangent_out[127:96]
    logic [WW-1:0] key_mem [KEY_DEPTH];

    // ---------------------------------------------------------------- wires
    logic                 in_fire;
    logic                 cmd;
    logic [kcs_pkg::SLOT_W-1:0] slot;
    logic                 slot_ok;
    logic [IW-1:0]        slot_idx;
    logic [CW-1:0]        cnt;
    logic [CW-1:0]        cnt_m1;
    logic [IW-1:0]        last;
    logic [IW-1:0]        ci;
    logic [IW-1:0]        rd_addr;
    logic signed [DW-1:0] mem_t;
    logic signed [DW-1:0] mem_v;
    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [MW-1:0] xs;
    logic signed [AW-1:0] fold_sum;
    logic signed [AW-1:0] lin_sum;
    logic signed [DW:0]   delta33;
    logic signed [DW:0]   d33;
    logic [DW:0]          mag;
    logic [DW-1:0]        rr;
    logic                 nz;
    logic                 odd;
    logic [DW-1:0]        rmod;
    logic signed [DW+1:0] fold_r;
    logic signed [DW:0]   num33;
    logic signed [DW:0]   den33;
    logic signed [HW-1:0] xpc;
    logic signed [HW-1:0] xh;
    logic                 div_done;
    logic [DVD_W-1:0]     div_quo;
    logic [DW-1:0]        div_rem;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign cmd      = s_axis_tuser[0];
    assign slot     = s_axis_tdata[5:0];
    assign slot_ok  = (32'(slot) < 32'(KEY_DEPTH));
    assign slot_idx = IW'(slot);

    // key count, capped at the memory depth
    assign cnt    = (32'(key_count_reg) > 32'(KEY_DEPTH)) ? CW'(KEY_DEPTH)
                                                           : CW'(key_count_reg);
    assign cnt_m1 = cnt - CW'(1);
    assign last   = cnt_m1[IW-1:0];
    assign ci     = (CW'(cached_reg) >= cnt) ? '0 : cached_reg;

    assign mem_t = mem_q_reg[DW-1:0];
    assign mem_v = mem_q_reg[2*DW-1:DW];

    assign xs = MW'($signed({1'b0, x_reg}));
    assign xh = HW'($signed({1'b0, x_reg}));

    assign fold_sum = (AW'(prod_reg) >>> FRAC_BITS) + AW'(offset_reg);
    assign lin_sum  = AW'(v1_reg) + (AW'(prod_reg) >>> FRAC_BITS);
    assign xpc      = HW'(prod_reg >>> FRAC_BITS);

    // fold: floor modulo taken on the magnitude, then corrected for sign
    assign delta33 = (DW+1)'(stop_reg) - (DW+1)'(start_reg);
    assign d33     = (DW+1)'(t_reg) - (DW+1)'(start_reg);
    assign mag     = d33[DW] ? (DW+1)'(-d33) : d33;
    assign rr      = div_rem;
    assign nz      = (rr != '0);
    assign odd     = div_quo[0] ^ (dneg_reg && nz);
    assign rmod    = dneg_reg ? (nz ? (delta_reg - rr) : '0) : rr;
    assign fold_r  = ((cycle_reg == kcs_pkg::CYCLE_PINGPONG) && odd)
                   ? ((DW+2)'(stop_reg) - $signed({2'b00, rmod}))
                   : ((DW+2)'(start_reg) + $signed({2'b00, rmod}));

    // shared divider for the fold and the key fraction
    kcs_div #(
        .DVD_W (DVD_W),
        .DVS_W (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start_reg),
        .dividend  (div_dvd_reg),
        .divisor   (div_dvs_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_flag_next  = out_flag_reg;
        div_start_next = 1'b0;
        cached_next    = cached_reg;
        res_val_next   = res_val_reg;
        res_ok_next    = res_ok_reg;
        tin_next       = tin_reg;
        t_next         = t_reg;
        tf_next        = tf_reg;
        delta_next     = delta_reg;
        dneg_next      = dneg_reg;
        bneg_next      = bneg_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        ti_next        = ti_reg;
        x_next         = x_reg;
        x2_next        = x2_reg;
        h00_next       = h00_reg;
        h01_next       = h01_reg;
        h10_next       = h10_reg;
        h11_next       = h11_reg;
        acc_next       = acc_reg;
        v1_next        = v1_reg;
        v2_next        = v2_reg;
        tout_next      = tout_reg;
        tinb_next      = tinb_reg;
        div_dvd_next   = div_dvd_reg;
        div_dvs_next   = div_dvs_reg;
        rd_addr        = '0;
        mul_a          = '0;
        mul_b          = '0;
        num33          = '0;
        den33          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (cmd == kcs_pkg::CMD_SAMPLE))
                begin
                    tin_next = s_axis_tdata[165:134];
                    if (cnt == '0)
                    begin
                        // no keys: answer zero, flag not valid, keep the cache
                        res_val_next = '0;
                        res_ok_next  = 1'b0;
                        state_next   = S_OUT;
                    end
                    else
                    begin
                        state_next = S_MAP;
                    end
                end
            end
            S_MAP:
            begin
                mul_a      = MW'(scale_reg);
                mul_b      = MW'(tin_reg);
                state_next = S_FOLD;
            end
            S_FOLD:
            begin
                t_next     = sat32(fold_sum);
                state_next = S_RANGE;
            end
            S_RANGE:
            begin
                priority if ((t_reg >= start_reg) && (t_reg <= stop_reg))
                begin
                    tf_next    = t_reg;
                    state_next = S_SRCH0;
                end
                else if ((cycle_reg == kcs_pkg::CYCLE_LOOP) ||
                         (cycle_reg == kcs_pkg::CYCLE_PINGPONG))
                begin
                    if (delta33 <= (DW+1)'(0))
                    begin
                        tf_next    = start_reg;
                        state_next = S_SRCH0;
                    end
                    else
                    begin
                        dneg_next      = d33[DW];
                        delta_next     = delta33[DW-1:0];
                        div_dvd_next   = DVD_W'(mag[DW-1:0]);
                        div_dvs_next   = delta33[DW-1:0];
                        div_start_next = 1'b1;
                        state_next     = S_MOD;
                    end
                end
                else
                begin
                    tf_next    = (t_reg < start_reg) ? start_reg : stop_reg;
                    state_next = S_SRCH0;
                end
            end
            S_MOD:
            begin
                if (div_done)
                begin
                    tf_next    = fold_r[DW-1:0];
                    state_next = S_SRCH0;
                end
            end
            S_SRCH0:
            begin
                rd_addr    = '0;
                state_next = S_SRCH1;
            end
            S_SRCH1:
            begin
                rd_addr = last;
                if (tf_reg <= mem_t)
                begin
                    a_next     = '0;
                    b_next     = '0;
                    x_next     = '0;
                    state_next = S_VA;
                end
                else
                begin
                    state_next = S_SRCH2;
                end
            end
            S_SRCH2:
            begin
                rd_addr = ci;
                if (tf_reg >= mem_t)
                begin
                    a_next     = last;
                    b_next     = last;
                    x_next     = '0;
                    state_next = S_VA;
                end
                else
                begin
                    i_next     = ci;
                    state_next = S_SRCH3;
                end
            end
            S_SRCH3:
            begin
                priority if (tf_reg > mem_t)
                begin
                    rd_addr    = i_reg + IW'(1);
                    ti_next    = mem_t;
                    j_next     = i_reg + IW'(1);
                    state_next = S_FWD;
                end
                else if ((tf_reg < mem_t) && (i_reg != '0))
                begin
                    rd_addr    = i_reg - IW'(1);
                    ti_next    = mem_t;
                    j_next     = i_reg - IW'(1);
                    state_next = S_BWD;
                end
                else
                begin
                    a_next     = i_reg;
                    b_next     = i_reg;
                    x_next     = '0;
                    state_next = S_VA;
                end
            end
            S_FWD:
            begin
                rd_addr = j_reg + IW'(1);
                num33   = (DW+1)'(tf_reg) - (DW+1)'(ti_reg);
                den33   = (DW+1)'(mem_t) - (DW+1)'(ti_reg);
                if ((j_reg < last) && (tf_reg >= mem_t))
                begin
                    // advance one key forward
                    i_next  = j_reg;
                    ti_next = mem_t;
                    j_next  = j_reg + IW'(1);
                end
                else
                begin
                    a_next         = i_reg;
                    b_next         = j_reg;
                    bneg_next      = 1'b0;
                    div_dvd_next   = {num33[DW-1:0], {FRAC_BITS{1'b0}}};
                    div_dvs_next   = den33[DW-1:0];
                    div_start_next = 1'b1;
                    state_next     = S_DIV;
                end
            end
            S_BWD:
            begin
                rd_addr = j_reg - IW'(1);
                num33   = (DW+1)'(ti_reg) - (DW+1)'(tf_reg);
                den33   = (DW+1)'(ti_reg) - (DW+1)'(mem_t);
                if ((j_reg != '0) && (tf_reg <= mem_t))
                begin
                    // step one key back
                    i_next  = j_reg;
                    ti_next = mem_t;
                    j_next  = j_reg - IW'(1);
                end
                else
                begin
                    a_next         = j_reg;
                    b_next         = i_reg;
                    bneg_next      = 1'b1;
                    div_dvd_next   = {num33[DW-1:0], {FRAC_BITS{1'b0}}};
                    div_dvs_next   = den33[DW-1:0];
                    div_start_next = 1'b1;
                    state_next     = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    x_next     = bneg_reg ? (ONE_X - div_quo[XW-1:0]) : div_quo[XW-1:0];
                    state_next = S_VA;
                end
            end
            S_VA:
            begin
                rd_addr     = a_reg;
                cached_next = a_reg;
                state_next  = S_VB;
            end
            S_VB:
            begin
                rd_addr    = b_reg;
                v1_next    = mem_v;
                tout_next  = mem_q_reg[4*DW-1:3*DW];
                state_next = S_VC;
            end
            S_VC:
            begin
                v2_next   = mem_v;
                tinb_next = mem_q_reg[3*DW-1:2*DW];
                priority if (interp_reg == kcs_pkg::INTERP_STEP)
                begin
                    res_val_next = (x_reg < HALF_X) ? v1_reg : mem_v;
                    res_ok_next  = 1'b1;
                    state_next   = S_OUT;
                end
                else if (interp_reg == kcs_pkg::INTERP_HERMITE)
                begin
                    state_next = S_HX2;
                end
                else
                begin
                    state_next = S_LM;
                end
            end
            S_LM:
            begin
                mul_a      = MW'(v2_reg) - MW'(v1_reg);
                mul_b      = xs;
                state_next = S_LFIN;
            end
            S_LFIN:
            begin
                res_val_next = sat32(lin_sum);
                res_ok_next  = 1'b1;
                state_next   = S_OUT;
            end
            S_HX2:
            begin
                mul_a      = xs;
                mul_b      = xs;
                state_next = S_HX3;
            end
            S_HX3:
            begin
                x2_next    = xpc;
                mul_a      = MW'(xpc);
                mul_b      = xs;
                state_next = S_HH;
            end
            S_HH:
            begin
                // Hermite basis from x, x^2 (x2_reg) and x^3 (xpc)
                h00_next   = (xpc <<< 1) - (x2_reg <<< 1) - x2_reg + ONE_H;
                h01_next   = x2_reg + (x2_reg <<< 1) - (xpc <<< 1);
                h10_next   = xpc - (x2_reg <<< 1) + xh;
                h11_next   = xpc - x2_reg;
                state_next = S_HM0;
            end
            S_HM0:
            begin
                mul_a      = MW'(v1_reg);
                mul_b      = MW'(h00_reg);
                state_next = S_HM1;
            end
            S_HM1:
            begin
                acc_next   = AW'(prod_reg);
                mul_a      = MW'(v2_reg);
                mul_b      = MW'(h01_reg);
                state_next = S_HM2;
            end
            S_HM2:
            begin
                acc_next   = acc_reg + AW'(prod_reg);
                mul_a      = MW'(tout_reg);
                mul_b      = MW'(h10_reg);
                state_next = S_HM3;
            end
            S_HM3:
            begin
                acc_next   = acc_reg + AW'(prod_reg);
                mul_a      = MW'(tinb_reg);
                mul_b      = MW'(h11_reg);
                state_next = S_HM4;
            end
            S_HM4:
            begin
                acc_next   = acc_reg + AW'(prod_reg);
                state_next = S_HFIN;
            end
            S_HFIN:
            begin
                res_val_next = sat32(acc_reg >>> FRAC_BITS);
                res_ok_next  = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_val_reg;
                    out_flag_next  = res_ok_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        prod_next = mul_a * mul_b;
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            div_start_reg <= 1'b0;
            cached_reg    <= '0;
            key_count_reg <= '0;
            interp_reg    <= kcs_pkg::INTERP_LINEAR;
            cycle_reg     <= kcs_pkg::CYCLE_CLAMP;
            start_reg     <= '0;
            stop_reg      <= '0;
            scale_reg     <= SCALE_RST;
            offset_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            div_start_reg <= div_start_next;
            cached_reg    <= cached_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    kcs_pkg::CFG_KEY_COUNT:   key_count_reg <= cfg_data[kcs_pkg::COUNT_W-1:0];
                    kcs_pkg::CFG_INTERP_MODE: interp_reg    <= cfg_data[kcs_pkg::MODE_W-1:0];
                    kcs_pkg::CFG_CYCLE_MODE:  cycle_reg     <= cfg_data[kcs_pkg::MODE_W-1:0];
                    kcs_pkg::CFG_RANGE_START: start_reg     <= cfg_data;
                    kcs_pkg::CFG_RANGE_STOP:  stop_reg      <= cfg_data;
                    kcs_pkg::CFG_TIME_SCALE:  scale_reg     <= cfg_data;
                    kcs_pkg::CFG_TIME_OFFSET: offset_reg    <= cfg_data;
                    default:
                    begin
                        // writes beyond the register list are dropped
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_flag_reg <= out_flag_next;
        res_val_reg  <= res_val_next;
        res_ok_reg   <= res_ok_next;
        tin_reg      <= tin_next;
        prod_reg     <= prod_next;
        t_reg        <= t_next;
        tf_reg       <= tf_next;
        delta_reg    <= delta_next;
        dneg_reg     <= dneg_next;
        bneg_reg     <= bneg_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        ti_reg       <= ti_next;
        x_reg        <= x_next;
        x2_reg       <= x2_next;
        h00_reg      <= h00_next;
        h01_reg      <= h01_next;
        h10_reg      <= h10_next;
        h11_reg      <= h11_next;
        acc_reg      <= acc_next;
        v1_reg       <= v1_next;
        v2_reg       <= v2_next;
        tout_reg     <= tout_next;
        tinb_reg     <= tinb_next;
        div_dvd_reg  <= div_dvd_next;
        div_dvs_reg  <= div_dvs_next;
    end

    // key memory: one write port for key transfers, one registered read port
    always_ff @(posedge clk)
    begin
        if (in_fire && (cmd == kcs_pkg::CMD_WRITE) && slot_ok)
        begin
            key_mem[slot_idx] <= {s_axis_tdata[133:102], s_axis_tdata[101:70],
                                  s_axis_tdata[69:38], s_axis_tdata[37:6]};
        end
        mem_q_reg <= key_mem[rd_addr];
    end

    // ---------------------------------------------------------------- ports
    assign s_axis_tready   = (state_reg == S_IDLE);
    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_flag_reg;

    // ---------------------------------------------------------------- checks
    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> ((state_reg == S_MOD) || (state_reg == S_DIV)))
        else $error("divider finished outside a division wait");

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_VA) |-> (x_reg <= ONE_X))
        else $error("key fraction above one");

    a_pair_in_keys: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_VB) |-> ((CW'(a_reg) < cnt) && (CW'(b_reg) < cnt)
                                 && (a_reg <= b_reg)))
        else $error("bracketing keys outside the keys in use");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_OUT) && out_valid_reg && !m_axis_tready)
        |=> (state_reg == S_OUT))
        else $error("result left the sequencer while the output was full");

endmodule

`default_nettype wire
